// ----- rtl/kuf_pkg.sv -----
// ----------------------------------------------------------------------------
// kuf_pkg
// Shared types and constants for the union-find spanning-tree edge filter.
// ----------------------------------------------------------------------------
package kuf_pkg;

	// field widths fixed by the item format
	localparam int NODE_W = 6;
	localparam int CNT_W = 6;
	localparam int CFG_W = 7;

	// largest node index space the 6-bit fields can name
	localparam int IDX_LIMIT = 1 << NODE_W;

	// default forest size and register reset value
	localparam int MAX_NODES_DEF = 64;
	localparam logic [CFG_W-1:0] NODE_COUNT_RST = CFG_W'(64);

	// accepted count saturates here
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// item opcodes
	typedef enum logic {
		ACT_CLEAR = 1'b0,
		ACT_EDGE  = 1'b1
	} kuf_action_t;

	// input beat
	typedef struct packed {
		kuf_action_t       action;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} kuf_in_t;

	// result beat
	typedef struct packed {
		logic              in_tree;
		logic              bad_index;
		logic [NODE_W-1:0] root_a;
		logic [NODE_W-1:0] root_b;
		logic [CNT_W-1:0]  accepted_total;
	} kuf_out_t;

	// parent store access from the sequencer
	typedef struct packed {
		logic [NODE_W-1:0] rd_addr;
		logic              wr_en;
		logic [NODE_W-1:0] wr_addr;
		logic [NODE_W-1:0] wr_data;
		logic              clr;
	} kuf_mem_req_t;

endpackage

// ----- rtl/kuf_parent_mem.sv -----
// ----------------------------------------------------------------------------
// kuf_parent_mem
// Parent pointer store: one write and one registered read per cycle. A valid
// bit per entry makes an unwritten entry read as its own index, so a clear
// of the whole forest only has to reset the valid bits.
// ----------------------------------------------------------------------------
module kuf_parent_mem #(
	parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  kuf_pkg::kuf_mem_req_t      req,
	output logic [kuf_pkg::NODE_W-1:0] parent
);

	localparam int DEPTH = (MAX_NODES < kuf_pkg::IDX_LIMIT) ? MAX_NODES : kuf_pkg::IDX_LIMIT;
	localparam int AW = $clog2(DEPTH);

	logic [AW-1:0]    mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	logic [AW-1:0]    rd_data_q;
	logic [AW-1:0]    rd_addr_q;
	logic             rd_vld_q;
	logic [AW-1:0]    ra;
	logic [AW-1:0]    wa;

	assign ra = req.rd_addr[AW-1:0];
	assign wa = req.wr_addr[AW-1:0];

	// storage array and registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[wa] <= req.wr_data[AW-1:0];
		end
		rd_data_q <= mem[ra];
		rd_vld_q <= vld_q[ra];
		rd_addr_q <= ra;
	end

	// entry valid bits, cleared all at once
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (req.clr) begin
			vld_q <= '0;
		end else if (req.wr_en) begin
			vld_q[wa] <= 1'b1;
		end
	end

	// unwritten entry points at itself
	assign parent = rd_vld_q ? kuf_pkg::NODE_W'(rd_data_q) : kuf_pkg::NODE_W'(rd_addr_q);

endmodule

// ----- rtl/kuf_seq.sv -----
// ----------------------------------------------------------------------------
// kuf_seq
// Sequencer for one item: for an edge, root walk and path compression for each
// endpoint, then the link of the two roots. One shared comparator judges the walk, compression and link steps.
// ----------------------------------------------------------------------------
module kuf_seq #(
	parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  kuf_pkg::kuf_in_t           item,
	input  logic [kuf_pkg::CFG_W-1:0]  node_count,
	input  logic                       take,
	input  logic [kuf_pkg::NODE_W-1:0] parent,
	output logic                       busy,
	output logic                       done,
	output kuf_pkg::kuf_out_t          res,
	output kuf_pkg::kuf_mem_req_t      mreq
);

	localparam int DEPTH = (MAX_NODES < kuf_pkg::IDX_LIMIT) ? MAX_NODES : kuf_pkg::IDX_LIMIT;
	localparam logic [kuf_pkg::CFG_W-1:0] DEPTH_C = kuf_pkg::CFG_W'(DEPTH);

	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_FPRIME = 7'b0000010,
		ST_FWALK  = 7'b0000100,
		ST_CPRIME = 7'b0001000,
		ST_CWALK  = 7'b0010000,
		ST_LINK   = 7'b0100000,
		ST_DONE   = 7'b1000000
	} kuf_state_t;

	kuf_state_t                 state_q;
	logic                       phase_q;
	logic [kuf_pkg::NODE_W-1:0] a_q;
	logic [kuf_pkg::NODE_W-1:0] b_q;
	logic [kuf_pkg::NODE_W-1:0] cur_q;
	logic [kuf_pkg::NODE_W-1:0] walk_q;
	logic [kuf_pkg::NODE_W-1:0] ra_q;
	logic [kuf_pkg::CNT_W-1:0]  count_q;
	kuf_pkg::kuf_out_t          res_q;

	logic [kuf_pkg::CFG_W-1:0]  limit;
	logic                       bad;
	logic [kuf_pkg::NODE_W-1:0] node_sel;
	logic [kuf_pkg::NODE_W-1:0] cmp_lhs;
	logic                       hit;
	logic [kuf_pkg::CNT_W-1:0]  count_inc;

	// endpoint range check against the smaller of register and store depth
	assign limit = (node_count < DEPTH_C) ? node_count : DEPTH_C;
	assign bad = ({1'b0, item.node_a} >= limit) || ({1'b0, item.node_b} >= limit);

	assign node_sel = phase_q ? b_q : a_q;
	assign count_inc = (count_q == kuf_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;

	// shared comparator: root test, end of compression, same-set test
	assign cmp_lhs = (state_q == ST_LINK) ? ra_q : parent;
	assign hit = (cmp_lhs == cur_q);

	// parent store requests
	always_comb begin
		mreq.rd_addr = cur_q;
		mreq.wr_en = 1'b0;
		mreq.wr_addr = walk_q;
		mreq.wr_data = cur_q;
		mreq.clr = start && (item.action == kuf_pkg::ACT_CLEAR);
		unique case (state_q)
			ST_FWALK: begin
				if (!hit) begin
					mreq.rd_addr = parent;
				end
			end
			ST_CPRIME: begin
				mreq.rd_addr = walk_q;
			end
			ST_CWALK: begin
				mreq.wr_en = 1'b1;
				if (!hit) begin
					mreq.rd_addr = parent;
				end
			end
			ST_LINK: begin
				mreq.wr_en = !hit;
				mreq.wr_addr = ra_q;
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (item.action == kuf_pkg::ACT_CLEAR) begin
							count_q <= '0;
							state_q <= ST_DONE;
						end else if (bad) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_FPRIME;
						end
					end
				end
				ST_FPRIME: begin
					state_q <= ST_FWALK;
				end
				ST_FWALK: begin
					if (hit) begin
						if (node_sel != cur_q) begin
							state_q <= ST_CPRIME;
						end else if (!phase_q) begin
							state_q <= ST_FPRIME;
						end else begin
							state_q <= ST_LINK;
						end
					end
				end
				ST_CPRIME: begin
					state_q <= ST_CWALK;
				end
				ST_CWALK: begin
					if (hit) begin
						state_q <= phase_q ? ST_LINK : ST_FPRIME;
					end
				end
				ST_LINK: begin
					if (!hit) begin
						count_q <= count_inc;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				a_q <= item.node_a;
				b_q <= item.node_b;
				cur_q <= item.node_a;
				phase_q <= 1'b0;
				res_q.in_tree <= 1'b0;
				res_q.bad_index <= (item.action == kuf_pkg::ACT_EDGE) && bad;
				res_q.root_a <= '0;
				res_q.root_b <= '0;
				res_q.accepted_total <= ((item.action == kuf_pkg::ACT_EDGE) && bad) ?
					count_q : '0;
			end
			ST_FWALK: begin
				if (hit) begin
					walk_q <= node_sel;
					if (node_sel == cur_q && !phase_q) begin
						phase_q <= 1'b1;
						ra_q <= cur_q;
						cur_q <= b_q;
					end
				end else begin
					cur_q <= parent;
				end
			end
			ST_CWALK: begin
				if (hit) begin
					if (!phase_q) begin
						phase_q <= 1'b1;
						ra_q <= cur_q;
						cur_q <= b_q;
					end
				end else begin
					walk_q <= parent;
				end
			end
			ST_LINK: begin
				res_q.in_tree <= !hit;
				res_q.bad_index <= 1'b0;
				res_q.root_a <= ra_q;
				res_q.root_b <= cur_q;
				res_q.accepted_total <= hit ? count_q : count_inc;
			end
			default: begin
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);
	assign res = res_q;

	// count only drops on a clear, which is taken in idle
	a_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |=> (count_q >= $past(count_q)))
		else $error("accepted count dropped during an edge");

	// a joined edge always has distinct roots
	a_join_roots: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_q.in_tree) |-> (res_q.root_a != res_q.root_b))
		else $error("edge joined with equal roots");

	// a rejected endpoint leaves no roots and no join
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && res_q.bad_index) |->
		(!res_q.in_tree && res_q.root_a == '0 && res_q.root_b == '0))
		else $error("bad index result carries join or roots");

	// compression never rewrites the root itself
	a_cwalk_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CWALK) |-> (walk_q != cur_q))
		else $error("path compression hit the root entry");

endmodule

// ----- rtl/kruskal_union_find_edge_filter_unit.sv -----
// ----------------------------------------------------------------------------
// kruskal_union_find_edge_filter_unit
// Disjoint-set edge filter for spanning-tree construction on pre-sorted edges.
// ----------------------------------------------------------------------------
// One beat at a time. A clear beat empties the forest when it is accepted, and
// its result is then handed over to the output register. An edge beat walks the
// parent store one pointer per cycle through a memory with one registered read
// port and one write port: for each endpoint it primes a read and climbs the
// links up to the root, and when the endpoint is not a root, it primes again
// and compresses each link on its path; then it links the two roots and hands
// the result over. An out-of-range endpoint is answered without a walk.
// item_stall is high from acceptance until the result is loaded into the
// output register, which can hold a finished beat while the next item runs.
module kruskal_union_find_edge_filter_unit #(
	parameter int MAX_NODES = kuf_pkg::MAX_NODES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      node_count_we,
	input  logic [kuf_pkg::CFG_W-1:0] node_count,
	input  logic                      item_valid,
	output logic                      item_stall,
	input  kuf_pkg::kuf_in_t          item,
	output logic                      result_valid,
	input  logic                      result_stall,
	output kuf_pkg::kuf_out_t         result
);

	logic [kuf_pkg::CFG_W-1:0]  node_count_q;
	logic                       result_valid_q;
	kuf_pkg::kuf_out_t          result_q;
	logic                       start;
	logic                       take;
	logic                       seq_busy;
	logic                       seq_done;
	kuf_pkg::kuf_out_t          seq_res;
	kuf_pkg::kuf_mem_req_t      mreq;
	logic [kuf_pkg::NODE_W-1:0] parent;

	// node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= kuf_pkg::NODE_COUNT_RST;
		end else if (node_count_we) begin
			node_count_q <= node_count;
		end
	end

	assign item_stall = seq_busy;
	assign start = item_valid && !seq_busy;
	assign take = seq_done && (!result_valid_q || !result_stall);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (take) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			result_q <= seq_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

	kuf_seq #(
		.MAX_NODES (MAX_NODES)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.item       (item),
		.node_count (node_count_q),
		.take       (take),
		.parent     (parent),
		.busy       (seq_busy),
		.done       (seq_done),
		.res        (seq_res),
		.mreq       (mreq)
	);

	kuf_parent_mem #(
		.MAX_NODES (MAX_NODES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mreq),
		.parent (parent)
	);

endmodule
